// ===== hdl/kvcfg_pkg.sv =====
// kvcfg_pkg: shared types and constants for the key/value line parser.
// Used by kvcfg_ctrl, kvcfg_datapath, the top level and the checker.
// No dependencies.
package kvcfg_pkg;

	// Result word part codes
	localparam logic [1:0] PART_KEY   = 2'd0;
	localparam logic [1:0] PART_VALUE = 2'd1;
	localparam logic [1:0] PART_END   = 2'd2;
	localparam logic [1:0] PART_ERR   = 2'd3;

	// Characters of interest
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_EQUAL = 8'h3D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NUL   = 8'h00;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_KEY,
		ST_VALUE,
		ST_END,
		ST_ERR
	} state_t;

	// Controller -> datapath
	typedef struct packed {
		logic accept;
		logic emit_key;
		logic emit_value;
		logic emit_end;
		logic emit_err;
		logic rewind;
		logic clear_record;
	} cmd_t;

	// Datapath -> controller
	typedef struct packed {
		logic close_req;
		logic err_req;
		logic key_done;
		logic value_done;
		logic out_free;
	} status_t;

endpackage

// ===== hdl/kvcfg_ctrl.sv =====
// kvcfg_ctrl: sequencer for intake, record replay and error reporting.
// Depends on kvcfg_pkg (state_t, cmd_t, status_t).
module kvcfg_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  kvcfg_pkg::status_t  status,
	output kvcfg_pkg::cmd_t     cmd
);

	kvcfg_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kvcfg_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			kvcfg_pkg::ST_IDLE: begin
				if (byte_valid && status.close_req) begin
					state_d = kvcfg_pkg::ST_KEY;
				end else if (byte_valid && status.err_req) begin
					state_d = kvcfg_pkg::ST_ERR;
				end
			end
			kvcfg_pkg::ST_KEY: begin
				if (status.key_done) begin
					state_d = kvcfg_pkg::ST_VALUE;
				end
			end
			kvcfg_pkg::ST_VALUE: begin
				if (status.value_done) begin
					state_d = kvcfg_pkg::ST_END;
				end
			end
			kvcfg_pkg::ST_END: begin
				if (status.out_free) begin
					state_d = kvcfg_pkg::ST_IDLE;
				end
			end
			kvcfg_pkg::ST_ERR: begin
				if (status.out_free) begin
					state_d = kvcfg_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = kvcfg_pkg::ST_IDLE;
			end
		endcase
	end

	// Outputs
	always_comb begin
		cmd        = '0;
		byte_stall = 1'b1;
		case (state_q)
			kvcfg_pkg::ST_IDLE: begin
				byte_stall = 1'b0;
				cmd.accept = byte_valid;
			end
			kvcfg_pkg::ST_KEY: begin
				if (status.key_done) begin
					cmd.rewind = 1'b1;
				end else begin
					cmd.emit_key = status.out_free;
				end
			end
			kvcfg_pkg::ST_VALUE: begin
				if (status.value_done) begin
					cmd.rewind = 1'b1;
				end else begin
					cmd.emit_value = status.out_free;
				end
			end
			kvcfg_pkg::ST_END: begin
				cmd.emit_end     = status.out_free;
				cmd.clear_record = status.out_free;
			end
			kvcfg_pkg::ST_ERR: begin
				cmd.emit_err = status.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ===== hdl/kvcfg_datapath.sv =====
// kvcfg_datapath: byte decode, mode flags, key/value stores, replay index
// and result word register. Depends on kvcfg_pkg (cmd_t, status_t, codes).
module kvcfg_datapath #(
	parameter int KEY_BUFFER_SIZE   = 16,
	parameter int VALUE_BUFFER_SIZE = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          text_byte,
	input  logic                end_of_file,
	input  kvcfg_pkg::cmd_t     cmd,
	output kvcfg_pkg::status_t  status,
	output logic                item_valid,
	input  logic                item_stall,
	output logic [1:0]          part,
	output logic [7:0]          character,
	output logic                last
);

	localparam int KEY_CAP = KEY_BUFFER_SIZE - 2;
	localparam int VAL_CAP = VALUE_BUFFER_SIZE - 2;
	localparam int KLW     = $clog2(KEY_CAP + 1);
	localparam int VLW     = $clog2(VAL_CAP + 1);
	localparam int KIW     = (KEY_CAP > 1) ? $clog2(KEY_CAP) : 1;
	localparam int VIW     = (VAL_CAP > 1) ? $clog2(VAL_CAP) : 1;
	localparam int RW      = (KLW > VLW) ? KLW : VLW;
	localparam logic [RW-1:0] KEY_CAP_R = RW'(KEY_CAP);
	localparam logic [RW-1:0] VAL_CAP_R = RW'(VAL_CAP);

	logic [7:0] key_mem [KEY_CAP];
	logic [7:0] val_mem [VAL_CAP];

	logic           comment_q, in_value_q, slash_q, halted_q, key0_space_q;
	logic [KLW-1:0] klen_q;
	logic [VLW-1:0] vlen_q;
	logic [RW-1:0]  rd_idx_q;

	logic           item_valid_q, last_q;
	logic [1:0]     part_q;
	logic [7:0]     char_q;

	// decode results
	logic           comment_d, in_value_d, slash_d, halted_d, clear_all;
	logic           slash_we, char_we, close_req, err_req, blank;
	logic [RW-1:0]  cur_len, cap, len_a, len_b;
	logic [KLW-1:0] klen_a;
	logic           key0_a, is_nl, go;

	assign is_nl = (text_byte == kvcfg_pkg::CH_LF) || (text_byte == kvcfg_pkg::CH_CR);

	always_comb begin
		comment_d  = comment_q;
		in_value_d = in_value_q;
		slash_d    = slash_q;
		halted_d   = halted_q;
		clear_all  = 1'b0;
		slash_we   = 1'b0;
		char_we    = 1'b0;
		close_req  = 1'b0;
		err_req    = 1'b0;
		go         = 1'b0;
		cur_len    = in_value_q ? RW'(vlen_q) : RW'(klen_q);
		cap        = in_value_q ? VAL_CAP_R : KEY_CAP_R;
		len_a      = cur_len;
		if (halted_q) begin
			clear_all = end_of_file;
		end else if (comment_q) begin
			if (is_nl) begin
				comment_d = 1'b0;
			end
		end else begin
			go = 1'b1;
			if (slash_q) begin
				slash_d = 1'b0;
				if (text_byte == kvcfg_pkg::CH_SLASH) begin
					comment_d = 1'b1;
					go        = 1'b0;
				end else if (cur_len < cap) begin
					slash_we = 1'b1;
					len_a    = cur_len + RW'(1);
				end else begin
					err_req = 1'b1;
					go      = 1'b0;
					if (end_of_file) begin
						clear_all = 1'b1;
					end else begin
						halted_d = 1'b1;
					end
				end
			end
		end
		len_b  = len_a;
		klen_a = in_value_q ? klen_q : len_a[KLW-1:0];
		key0_a = (slash_we && !in_value_q && (cur_len == '0)) ? 1'b0 : key0_space_q;
		blank  = (klen_a == '0) || ((klen_a == KLW'(1)) && key0_a);
		if (go) begin
			if (end_of_file) begin
				if (!is_nl && (len_a < cap)) begin
					char_we = 1'b1;
					len_b   = len_a + RW'(1);
				end
				close_req = 1'b1;
			end else if (text_byte == kvcfg_pkg::CH_SLASH) begin
				slash_d = 1'b1;
			end else if (text_byte == kvcfg_pkg::CH_EQUAL) begin
				in_value_d = 1'b1;
			end else if (is_nl) begin
				close_req = !blank;
			end else if (len_a < cap) begin
				char_we = 1'b1;
				len_b   = len_a + RW'(1);
			end else begin
				err_req  = 1'b1;
				halted_d = 1'b1;
			end
		end
	end

	// Mode flags and lengths
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			comment_q    <= 1'b0;
			in_value_q   <= 1'b0;
			slash_q      <= 1'b0;
			halted_q     <= 1'b0;
			key0_space_q <= 1'b0;
			klen_q       <= '0;
			vlen_q       <= '0;
		end else if (cmd.accept) begin
			if (clear_all) begin
				comment_q  <= 1'b0;
				in_value_q <= 1'b0;
				slash_q    <= 1'b0;
				halted_q   <= 1'b0;
				klen_q     <= '0;
				vlen_q     <= '0;
			end else begin
				comment_q  <= comment_d;
				in_value_q <= in_value_d;
				slash_q    <= slash_d;
				halted_q   <= halted_d;
				if (in_value_q) begin
					vlen_q <= len_b[VLW-1:0];
				end else begin
					klen_q <= len_b[KLW-1:0];
					if (char_we && (len_a == '0)) begin
						key0_space_q <= (text_byte == kvcfg_pkg::CH_SPACE);
					end else if (slash_we && (cur_len == '0)) begin
						key0_space_q <= 1'b0;
					end
				end
			end
		end else if (cmd.clear_record) begin
			comment_q  <= 1'b0;
			in_value_q <= 1'b0;
			slash_q    <= 1'b0;
			klen_q     <= '0;
			vlen_q     <= '0;
		end
	end

	// Stores: held '/' first, then the byte itself, same store
	always_ff @(posedge clk) begin
		if (cmd.accept && !clear_all) begin
			if (in_value_q) begin
				if (slash_we) begin
					val_mem[cur_len[VIW-1:0]] <= kvcfg_pkg::CH_SLASH;
				end
				if (char_we) begin
					val_mem[len_a[VIW-1:0]] <= text_byte;
				end
			end else begin
				if (slash_we) begin
					key_mem[cur_len[KIW-1:0]] <= kvcfg_pkg::CH_SLASH;
				end
				if (char_we) begin
					key_mem[len_a[KIW-1:0]] <= text_byte;
				end
			end
		end
	end

	// Replay index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q <= '0;
		end else if (cmd.rewind || cmd.clear_record) begin
			rd_idx_q <= '0;
		end else if (cmd.emit_key || cmd.emit_value) begin
			rd_idx_q <= rd_idx_q + RW'(1);
		end
	end

	// Result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_q <= 1'b0;
		end else if (cmd.emit_key || cmd.emit_value || cmd.emit_end || cmd.emit_err) begin
			item_valid_q <= 1'b1;
		end else if (!item_stall) begin
			item_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_key) begin
			part_q <= kvcfg_pkg::PART_KEY;
			char_q <= key_mem[rd_idx_q[KIW-1:0]];
			last_q <= 1'b0;
		end else if (cmd.emit_value) begin
			part_q <= kvcfg_pkg::PART_VALUE;
			char_q <= val_mem[rd_idx_q[VIW-1:0]];
			last_q <= 1'b0;
		end else if (cmd.emit_end) begin
			part_q <= kvcfg_pkg::PART_END;
			char_q <= kvcfg_pkg::CH_NUL;
			last_q <= 1'b1;
		end else if (cmd.emit_err) begin
			part_q <= kvcfg_pkg::PART_ERR;
			char_q <= kvcfg_pkg::CH_NUL;
			last_q <= 1'b1;
		end
	end

	assign status.close_req  = close_req;
	assign status.err_req    = err_req;
	assign status.key_done   = (rd_idx_q == RW'(klen_q));
	assign status.value_done = (rd_idx_q == RW'(vlen_q));
	assign status.out_free   = !item_valid_q || !item_stall;

	assign item_valid = item_valid_q;
	assign part       = part_q;
	assign character  = char_q;
	assign last       = last_q;

endmodule

// ===== hdl/key_value_config_line_parser.sv =====
// key_value_config_line_parser: top level, splits key=value text lines.
// Depends on kvcfg_pkg, kvcfg_ctrl and kvcfg_datapath.
//
//  channel  dir  handshake               fields
//  byte     in   byte_valid/byte_stall   text_byte[7:0], end_of_file
//  item     out  item_valid/item_stall   part[1:0], character[7:0], last
//
// A byte that causes no result does not stall; the next byte can follow at once.
// A byte that closes a record stalls intake while the record is replayed: the
// replay sequencer reads one stored character per cycle unless item_stall holds
// it, and takes a turning step from key to value and from value to the end word.
// An overflow error word holds intake until the error word is issued.
// arst_n clears modes, lengths, replay index and item_valid; stores need no clear.
// A waiting result word does not block intake while the sequencer is idle.
module key_value_config_line_parser #(
	parameter int KEY_BUFFER_SIZE   = 16,
	parameter int VALUE_BUFFER_SIZE = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_stall,
	input  logic [7:0] text_byte,
	input  logic       end_of_file,
	output logic       item_valid,
	input  logic       item_stall,
	output logic [1:0] part,
	output logic [7:0] character,
	output logic       last
);

	kvcfg_pkg::cmd_t    cmd;
	kvcfg_pkg::status_t status;

	// Sequencer: intake, key replay, value replay, record end, error word
	kvcfg_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.status     (status),
		.cmd        (cmd)
	);

	// Datapath: decode of the current byte, comment/slash/value/halt modes,
	// the two character stores and the registered result word
	kvcfg_datapath #(
		.KEY_BUFFER_SIZE   (KEY_BUFFER_SIZE),
		.VALUE_BUFFER_SIZE (VALUE_BUFFER_SIZE)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.text_byte   (text_byte),
		.end_of_file (end_of_file),
		.cmd         (cmd),
		.status      (status),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.part        (part),
		.character   (character),
		.last        (last)
	);

endmodule

// ===== hdl/kvcfg_checker.sv =====
// kvcfg_checker: port-level assertions for key_value_config_line_parser.
// Depends on kvcfg_pkg; bound to the top level at the end of this file.
module kvcfg_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       byte_valid,
	input logic       byte_stall,
	input logic       item_valid,
	input logic       item_stall,
	input logic [1:0] part,
	input logic [7:0] character,
	input logic       last
);

	// A stalled result word stays offered
	a_item_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_stall |=> item_valid)
		else $error("result word dropped while stalled");

	// Only record-end and error words close a run
	a_last_code: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid |-> (last == ((part == kvcfg_pkg::PART_END) ||
			(part == kvcfg_pkg::PART_ERR))))
		else $error("last flag does not match part code");

	// Record-end and error words carry no character
	a_nul_char: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && ((part == kvcfg_pkg::PART_END) || (part == kvcfg_pkg::PART_ERR))
		|-> (character == kvcfg_pkg::CH_NUL))
		else $error("non-zero character on end or error word");

	// Intake closes only right after a byte is taken
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(byte_stall) |-> $past(byte_valid && !byte_stall))
		else $error("intake stalled without an accepted byte");

endmodule

bind key_value_config_line_parser kvcfg_checker u_kvcfg_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.byte_valid (byte_valid),
	.byte_stall (byte_stall),
	.item_valid (item_valid),
	.item_stall (item_stall),
	.part       (part),
	.character  (character),
	.last       (last)
);

// ===== tb/tb_top.sv =====
// tb_top: self-checking bench for key_value_config_line_parser, fed with text files.
// Predicts the key/value/end/error words of every byte and checks each output word.
// Depends on kvcfg_pkg and key_value_config_line_parser.
module tb_top;

	localparam int KEY_BUFFER_SIZE   = 16;
	localparam int VALUE_BUFFER_SIZE = 32;
	localparam int KEY_CAP           = KEY_BUFFER_SIZE - 2;
	localparam int VALUE_CAP         = VALUE_BUFFER_SIZE - 2;
	localparam int LONG_HOLD_CYCLES  = 150;
	// Worst replay is a full key and value plus the turn and end cycles.
	localparam int SETTLE_CYCLES     = KEY_CAP + VALUE_CAP + 16;

	logic       clk;
	logic       arst_n;
	logic       byte_valid;
	logic       byte_stall;
	logic [7:0] text_byte;
	logic       end_of_file;
	logic       item_valid;
	logic       item_stall;
	logic [1:0] part;
	logic [7:0] character;
	logic       last;

	// calm: both sides run flat out. long_hold: sink parks for a long stretch.
	bit calm;
	bit long_hold;
	int live_bytes;

	typedef struct packed {
		logic [1:0] part;
		logic [7:0] ch;
		logic       last;
	} item_word_t;

	// Own copy of the parser state; turns each accepted byte into the words it
	// should cause and holds them until the sink sees them.
	class line_record_predictor;
		item_word_t expected_words[$];
		int         mismatches;
		bit         comment_on;
		bit         value_mode;
		bit         slash_held;
		bit         halted;
		logic [7:0] key_store[KEY_CAP];
		logic [7:0] value_store[VALUE_CAP];
		int         key_len;
		int         value_len;

		function new();
			mismatches = 0;
			clear_all();
		endfunction

		function void clear_all();
			comment_on = 1'b0;
			value_mode = 1'b0;
			slash_held = 1'b0;
			halted     = 1'b0;
			key_len    = 0;
			value_len  = 0;
		endfunction

		function bit is_newline(logic [7:0] c);
			return c == kvcfg_pkg::CH_LF || c == kvcfg_pkg::CH_CR;
		endfunction

		function void push_word(logic [1:0] p, logic [7:0] c, logic l);
			item_word_t w;
			w.part = p;
			w.ch   = c;
			w.last = l;
			expected_words.push_back(w);
		endfunction

		// false when the active store is already full
		function bit store_char(logic [7:0] c);
			if (!value_mode) begin
				if (key_len < KEY_CAP) begin
					key_store[key_len] = c;
					key_len++;
					return 1'b1;
				end
				return 1'b0;
			end
			if (value_len < VALUE_CAP) begin
				value_store[value_len] = c;
				value_len++;
				return 1'b1;
			end
			return 1'b0;
		endfunction

		// replay key, then value, then the end word; the end word is always last
		function void close_record();
			for (int i = 0; i < key_len; i++)
				push_word(kvcfg_pkg::PART_KEY, key_store[i], 1'b0);
			for (int i = 0; i < value_len; i++)
				push_word(kvcfg_pkg::PART_VALUE, value_store[i], 1'b0);
			push_word(kvcfg_pkg::PART_END, kvcfg_pkg::CH_NUL, 1'b1);
			key_len    = 0;
			value_len  = 0;
			value_mode = 1'b0;
			comment_on = 1'b0;
			slash_held = 1'b0;
		endfunction

		// returns 0 when the byte was swallowed by the halt after an error
		function bit take_byte(logic [7:0] c, logic eof);
			if (halted) begin
				if (eof)
					clear_all();
				return 1'b0;
			end
			if (comment_on) begin
				if (is_newline(c))
					comment_on = 1'b0;
				return 1'b1;
			end
			if (slash_held) begin
				slash_held = 1'b0;
				if (c == kvcfg_pkg::CH_SLASH) begin
					comment_on = 1'b1;
					return 1'b1;
				end
				if (!store_char(kvcfg_pkg::CH_SLASH)) begin
					push_word(kvcfg_pkg::PART_ERR, kvcfg_pkg::CH_NUL, 1'b1);
					if (eof)
						clear_all();
					else
						halted = 1'b1;
					return 1'b1;
				end
			end
			if (eof) begin
				if (!is_newline(c))
					void'(store_char(c));
				close_record();
				return 1'b1;
			end
			if (c == kvcfg_pkg::CH_SLASH) begin
				slash_held = 1'b1;
			end else if (c == kvcfg_pkg::CH_EQUAL) begin
				value_mode = 1'b1;
			end else if (is_newline(c)) begin
				if (!(key_len == 0 || (key_len == 1 && key_store[0] == kvcfg_pkg::CH_SPACE)))
					close_record();
			end else if (!store_char(c)) begin
				push_word(kvcfg_pkg::PART_ERR, kvcfg_pkg::CH_NUL, 1'b1);
				halted = 1'b1;
			end
			return 1'b1;
		endfunction

		function void check_word(item_word_t got);
			item_word_t want;
			if (expected_words.size() == 0) begin
				if (mismatches < 10)
					$display("ERROR %0t: surplus word part=%0d char=%02h last=%0d",
						$realtime, got.part, got.ch, got.last);
				mismatches++;
				return;
			end
			want = expected_words.pop_front();
			if (got !== want) begin
				if (mismatches < 10)
					$display({"ERROR %0t: want part=%0d char=%02h last=%0d, ",
						"got part=%0d char=%02h last=%0d"},
						$realtime, want.part, want.ch, want.last, got.part, got.ch,
						got.last);
				mismatches++;
			end
		endfunction

		function int pending();
			return expected_words.size();
		endfunction
	endclass

	line_record_predictor sb = new();

	key_value_config_line_parser #(
		.KEY_BUFFER_SIZE  (KEY_BUFFER_SIZE),
		.VALUE_BUFFER_SIZE(VALUE_BUFFER_SIZE)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.text_byte  (text_byte),
		.end_of_file(end_of_file),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.part       (part),
		.character  (character),
		.last       (last)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard stop well beyond the slowest legal run.
	initial begin
		#(8 * 2000000);
		$display("Mismatches found");
		$finish;
	end

	// Sender: drives at the falling edge, counts acceptance at the rising edge.
	// A nonzero gap drops valid before the byte; otherwise the next byte follows
	// straight on with valid held high.
	task automatic send_byte(input logic [7:0] b, input logic eof);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			@(negedge clk) byte_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		byte_valid  <= 1'b1;
		text_byte   <= b;
		end_of_file <= eof;
		do @(posedge clk); while (byte_stall);
		if (sb.take_byte(b, eof))
			live_bytes++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], 1'b0);
	endtask

	// Mostly printable characters with no parser meaning; now and then any byte.
	function automatic logic [7:0] plain_char();
		logic [7:0] c;
		if ($urandom_range(0, 7) == 0)
			return 8'($urandom_range(0, 255));
		do c = 8'($urandom_range(8'h20, 8'h7E));
		while (c == kvcfg_pkg::CH_SLASH || c == kvcfg_pkg::CH_EQUAL);
		return c;
	endfunction

	task automatic send_chars(input int n);
		repeat (n) send_byte(plain_char(), 1'b0);
	endtask

	function automatic logic [7:0] newline_char();
		return $urandom_range(0, 1) ? kvcfg_pkg::CH_LF : kvcfg_pkg::CH_CR;
	endfunction

	// Sender stops offering and waits for the sink to take every word owed.
	task automatic hold_until_drained();
		@(negedge clk) byte_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// One file: a few lines of assorted shapes, closed by the end-of-file byte.
	// Key and value lengths stay short mostly, with the odd run at the store edge
	// so that overflow (and the halt it causes) turns up regularly.
	task automatic send_random_file();
		int lines;
		int kind;
		int sel;
		lines = $urandom_range(1, 5);
		repeat (lines) begin
			kind = $urandom_range(0, 9);
			case (kind)
			0, 1, 2, 3, 4: begin
				sel = $urandom_range(0, 15);
				if (sel == 0)
					;
				else if (sel == 1)
					send_chars($urandom_range(KEY_CAP - 1, KEY_CAP + 2));
				else if (sel == 2)
					send_byte(kvcfg_pkg::CH_SPACE, 1'b0);
				else
					send_chars($urandom_range(1, 6));
				send_byte(kvcfg_pkg::CH_EQUAL, 1'b0);
				if ($urandom_range(0, 15) == 0)
					send_chars($urandom_range(VALUE_CAP - 2, VALUE_CAP + 2));
				else
					send_chars($urandom_range(0, 8));
				send_byte(newline_char(), 1'b0);
			end
			5: begin
				send_text("//");
				send_chars($urandom_range(0, 6));
				send_byte(newline_char(), 1'b0);
			end
			6: begin
				send_chars($urandom_range(1, 4));
				send_byte(kvcfg_pkg::CH_EQUAL, 1'b0);
				send_chars($urandom_range(0, 3));
				send_text("//");
				send_chars($urandom_range(0, 4));
				send_byte(newline_char(), 1'b0);
			end
			7: begin
				send_chars($urandom_range(1, 3));
				send_byte(kvcfg_pkg::CH_SLASH, 1'b0);
				send_chars($urandom_range(1, 3));
				send_byte(kvcfg_pkg::CH_EQUAL, 1'b0);
				send_byte(kvcfg_pkg::CH_SLASH, 1'b0);
				send_chars($urandom_range(0, 2));
				send_byte(newline_char(), 1'b0);
			end
			8: begin
				repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)), 1'b0);
			end
			default: begin
				send_chars($urandom_range(1, 3));
				send_byte(kvcfg_pkg::CH_EQUAL, 1'b0);
				send_chars($urandom_range(1, 2));
				send_byte(kvcfg_pkg::CH_EQUAL, 1'b0);
				send_chars($urandom_range(1, 2));
				send_byte(newline_char(), 1'b0);
				send_byte(newline_char(), 1'b0);
			end
			endcase
		end
		sel = $urandom_range(0, 7);
		case (sel)
		0: send_byte(newline_char(), 1'b1);
		1: send_byte(kvcfg_pkg::CH_SLASH, 1'b1);
		2: send_byte(kvcfg_pkg::CH_EQUAL, 1'b1);
		3: begin
			// a key near the store edge then a held slash: with a full key the slash overflows on the last byte
			send_chars($urandom_range(KEY_CAP - 2, KEY_CAP + 1));
			send_byte(kvcfg_pkg::CH_SLASH, 1'b0);
			send_byte(8'($urandom_range(0, 255)), 1'b1);
		end
		default: send_byte(8'($urandom_range(0, 255)), 1'b1);
		endcase
	endtask

	// Sink: draws a stall per word, or parks for a long stretch on request, and
	// checks every word it takes against the oldest prediction.
	initial begin
		int hold;
		item_word_t got;
		item_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			hold = calm ? 0 : $urandom_range(0, 6);
			if (long_hold) begin
				hold = LONG_HOLD_CYCLES;
				long_hold = 1'b0;
			end
			if (hold > 0) begin
				@(negedge clk) item_stall <= 1'b1;
				repeat (hold - 1) @(negedge clk);
				@(negedge clk) item_stall <= 1'b0;
			end
			do @(posedge clk); while (!item_valid);
			got.part = part;
			got.ch   = character;
			got.last = last;
			sb.check_word(got);
		end
	end

	initial begin
		int file_idx;
		arst_n      = 1'b0;
		byte_valid  = 1'b0;
		text_byte   = 8'h00;
		end_of_file = 1'b0;
		calm        = 1'b0;
		long_hold   = 1'b0;
		live_bytes  = 0;
		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Directed file: plain record, comment line, blank key keeping its value,
		// the byte extremes in a value, a held slash in a key, a mid-line comment
		// whose newline leaves the record open, and a final slash stored as data.
		send_text("k=v\n");
		send_text("//c\r");
		send_text(" =w\n");
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(kvcfg_pkg::CH_CR, 1'b0);
		send_byte("z", 1'b1);
		send_text("a/b=c//x\n");
		send_byte(kvcfg_pkg::CH_SLASH, 1'b1);
		hold_until_drained();

		// Random files; every fourth runs with no idling on either side.
		file_idx = 0;
		while (live_bytes < 420) begin
			calm = (file_idx % 4 == 2);
			// sink parks while lines keep coming, so the replay backs up into intake
			if (file_idx == 3)
				long_hold = 1'b1;
			if (file_idx == 6)
				hold_until_drained();
			send_random_file();
			file_idx++;
		end
		calm = 1'b0;

		hold_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
